[hw/rtl/twgt_pkg.sv]
// Shared types and constants of the twiddle gain tuner.
// Holds the gain, step and tuner state types and the configuration register map.
// Depends on nothing; every other file of the block refers to it by scoped names.
package twgt_pkg;

	// Widths fixed by the register and field formats.
	localparam int GAIN_W  = 32;
	localparam int STEP_W  = 31;
	localparam int RUNLEN_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef logic [STEP_W-1:0] step_t;

	// Gain being tuned, in the order proportional, integral, derivative.
	typedef enum logic [1:0] {
		GAIN_P = 2'd0,
		GAIN_I = 2'd1,
		GAIN_D = 2'd2
	} gain_sel_t;

	// Trial phase of the selected gain.
	typedef enum logic [1:0] {
		PH_ADD     = 2'd0,
		PH_RETRY   = 2'd1,
		PH_RESTORE = 2'd2
	} phase_t;

	// Everything the search carries from one run end to the next.
	typedef struct packed {
		gain_t [2:0] gain;
		step_t [2:0] step;
		gain_sel_t   sel;
		phase_t      phase;
		gain_t       best;
		logic        baseline;
	} tune_state_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TUNE_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_GAIN_P = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_GAIN_I = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_GAIN_D = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_P = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_I = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_D = 3'd7;

	// Register values after reset.
	localparam logic [RUNLEN_W-1:0] RUN_LENGTH_RST = 16'd500;
	localparam gain_t INIT_GAIN_P_RST = 32'sd19005;
	localparam gain_t INIT_GAIN_I_RST = 32'sd144;
	localparam gain_t INIT_GAIN_D_RST = 32'sd320537;
	localparam step_t INIT_STEP_P_RST = 31'd6554;
	localparam step_t INIT_STEP_I_RST = 31'd131;
	localparam step_t INIT_STEP_D_RST = 31'd65536;

endpackage

[hw/rtl/twgt_step_scale.sv]
// Step scaler: multiplies a search step by the growth or shrink factor.
// Rounds half up, drops the fraction bits and saturates to the step range.
// Depends on twgt_pkg for the step type.
module twgt_step_scale #(
	parameter int FRAC_BITS = 16
) (
	input  twgt_pkg::step_t step,
	input  logic            grow,
	output twgt_pkg::step_t scaled
);

	localparam int FACT_W = FRAC_BITS + 1;
	localparam int PROD_W = twgt_pkg::STEP_W + 1 + FRAC_BITS;
	localparam logic [FACT_W-1:0] GROW_FACTOR =
		FACT_W'(((64'd11 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [FACT_W-1:0] SHRINK_FACTOR =
		FACT_W'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

	logic [FACT_W-1:0] factor;
	logic [PROD_W-1:0] product;
	logic [PROD_W-1:0] rounded;
	logic [twgt_pkg::STEP_W:0] whole;

	// One multiply, a rounding add and a saturating cut to 31 bits.
	assign factor  = grow ? GROW_FACTOR : SHRINK_FACTOR;
	assign product = PROD_W'(step) * PROD_W'(factor);
	assign rounded = product + HALF_LSB;
	assign whole   = rounded[PROD_W-1:FRAC_BITS];
	assign scaled  = whole[twgt_pkg::STEP_W] ? '1 : whole[twgt_pkg::STEP_W-1:0];

endmodule

[hw/rtl/twgt_twiddle_core.sv]
// Twiddle update for one run end: baseline capture and the phase machine
// of the selected gain. Purely combinational; the caller registers the result.
// Depends on twgt_pkg and twgt_step_scale.
module twgt_twiddle_core #(
	parameter int FRAC_BITS = 16
) (
	input  twgt_pkg::tune_state_t cur,
	input  twgt_pkg::gain_t       run_error,
	output twgt_pkg::tune_state_t nxt
);

	twgt_pkg::gain_t     g_sel;
	twgt_pkg::step_t     s_sel;
	twgt_pkg::step_t     s_scaled;
	twgt_pkg::gain_t     g_new;
	twgt_pkg::gain_sel_t sel_next;
	logic                better;
	logic                step_back;
	logic signed [twgt_pkg::GAIN_W+1:0] delta;
	logic signed [twgt_pkg::GAIN_W+1:0] sum;

	assign g_sel  = cur.gain[cur.sel];
	assign s_sel  = cur.step[cur.sel];
	assign better = $signed(run_error) < $signed(cur.best);

	// The retry phase moves the gain back by two steps; otherwise it moves up one.
	assign step_back = (cur.phase == twgt_pkg::PH_RETRY);
	assign delta = step_back ? -$signed({2'b00, s_sel, 1'b0}) : $signed({3'b000, s_sel});
	assign sum   = $signed({{2{g_sel[twgt_pkg::GAIN_W-1]}}, g_sel}) + delta;

	// Saturate the exact sum to the signed gain range.
	always_comb begin
		if (sum[twgt_pkg::GAIN_W+1:twgt_pkg::GAIN_W-1] == 3'b000 ||
		    sum[twgt_pkg::GAIN_W+1:twgt_pkg::GAIN_W-1] == 3'b111) begin
			g_new = sum[twgt_pkg::GAIN_W-1:0];
		end else if (sum[twgt_pkg::GAIN_W+1]) begin
			g_new = {1'b1, {(twgt_pkg::GAIN_W-1){1'b0}}};
		end else begin
			g_new = {1'b0, {(twgt_pkg::GAIN_W-1){1'b1}}};
		end
	end

	// A better run grows the step; a failed restore shrinks it.
	twgt_step_scale #(
		.FRAC_BITS(FRAC_BITS)
	) u_step_scale (
		.step  (s_sel),
		.grow  (better),
		.scaled(s_scaled)
	);

	// Next gain in the round robin.
	always_comb begin
		case (cur.sel)
			twgt_pkg::GAIN_P: sel_next = twgt_pkg::GAIN_I;
			twgt_pkg::GAIN_I: sel_next = twgt_pkg::GAIN_D;
			default:          sel_next = twgt_pkg::GAIN_P;
		endcase
	end

	// Phase machine of the selected gain.
	always_comb begin
		nxt = cur;
		if (!cur.baseline) begin
			nxt.best     = run_error;
			nxt.baseline = 1'b1;
		end else begin
			case (cur.phase)
				twgt_pkg::PH_ADD: begin
					nxt.gain[cur.sel] = g_new;
					nxt.phase         = twgt_pkg::PH_RETRY;
				end
				default: begin
					if (better) begin
						nxt.step[cur.sel] = s_scaled;
						nxt.best          = run_error;
						nxt.sel           = sel_next;
						nxt.phase         = twgt_pkg::PH_ADD;
					end else if (step_back) begin
						nxt.gain[cur.sel] = g_new;
						nxt.phase         = twgt_pkg::PH_RESTORE;
					end else begin
						nxt.gain[cur.sel] = g_new;
						nxt.step[cur.sel] = s_scaled;
						nxt.sel           = sel_next;
						nxt.phase         = twgt_pkg::PH_ADD;
					end
				end
			endcase
		end
	end

endmodule

[hw/rtl/twiddle_gain_tuner_unit.sv]
// Twiddle gain tuner for the three gains of a PID controller.
// Channels: one error beat in (run_error), one gain beat out at each run end.
// Uses the state types from twgt_pkg and the update logic in twgt_twiddle_core.
//
// Each accepted input beat is one control tick. The tick counter runs up to
// run_length; the tick after that ends the run, updates the search state and
// produces one output beat with the three gains, restart set, and the gain
// now being tuned. Ticks that do not end a run produce nothing.
//
// An input beat is captured in the input register and processed from there,
// which writes the output register that presents the output beat.
// A new tick is taken in every cycle while in_stall is low, and run ends
// may follow back to back while the receiver takes each result.
// When the receiver stalls with a result held, a further tick that would end
// a run waits in the input register and in_stall rises; other ticks pass.
// Reset loads the register defaults, the initial gains and steps, and clears
// the counter and the search state; the tuner starts disabled. Writing 1 to
// tune_enable while it is 0 reloads gains and steps from the init registers.
module twiddle_gain_tuner_unit #(
	parameter int FRAC_BITS   = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [twgt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [twgt_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Tick channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  twgt_pkg::gain_t                      run_error,
	// Result channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output twgt_pkg::gain_t                      gain_p_out,
	output twgt_pkg::gain_t                      gain_i_out,
	output twgt_pkg::gain_t                      gain_d_out,
	output logic                                 restart,
	output logic [1:0]                           tuned_gain
);

	localparam int CMP_W = (COUNT_WIDTH + 1 > twgt_pkg::RUNLEN_W) ?
		COUNT_WIDTH + 1 : twgt_pkg::RUNLEN_W;

	// Configuration registers.
	logic                              enable_q;
	logic [twgt_pkg::RUNLEN_W-1:0]     run_len_q;
	twgt_pkg::gain_t                   init_gain_p_q;
	twgt_pkg::gain_t                   init_gain_i_q;
	twgt_pkg::gain_t                   init_gain_d_q;
	twgt_pkg::step_t                   init_step_p_q;
	twgt_pkg::step_t                   init_step_i_q;
	twgt_pkg::step_t                   init_step_d_q;

	// Tuner state.
	logic [COUNT_WIDTH-1:0]            count_q;
	twgt_pkg::tune_state_t             state_q;
	twgt_pkg::tune_state_t             state_nxt;
	twgt_pkg::tune_state_t             session_start;

	// Input stage.
	logic                              valid_s1;
	twgt_pkg::gain_t                   err_s1;

	// Output register.
	logic                              out_valid_q;
	twgt_pkg::gain_t                   gain_p_q;
	twgt_pkg::gain_t                   gain_i_q;
	twgt_pkg::gain_t                   gain_d_q;
	twgt_pkg::gain_sel_t               tuned_q;

	logic [CMP_W-1:0]                  count_next;
	logic                              run_end;
	logic                              out_free;
	logic                              proceed;
	logic                              emit;

	// Run end detection on the registered tick.
	assign count_next = CMP_W'(count_q) + CMP_W'(1);
	assign run_end    = enable_q && (count_next > CMP_W'(run_len_q));

	// A tick goes on unless it ends a run while a result still waits.
	assign out_free = !out_valid_q || !out_stall;
	assign proceed  = valid_s1 && (!run_end || out_free);
	assign emit     = proceed && run_end;
	assign in_stall = valid_s1 && !proceed;

	// Search state at the start of a session.
	always_comb begin
		session_start          = state_q;
		session_start.gain[0]  = init_gain_p_q;
		session_start.gain[1]  = init_gain_i_q;
		session_start.gain[2]  = init_gain_d_q;
		session_start.step[0]  = init_step_p_q;
		session_start.step[1]  = init_step_i_q;
		session_start.step[2]  = init_step_d_q;
		session_start.sel      = twgt_pkg::GAIN_P;
		session_start.phase    = twgt_pkg::PH_ADD;
		session_start.best     = '0;
		session_start.baseline = 1'b0;
	end

	twgt_twiddle_core #(
		.FRAC_BITS(FRAC_BITS)
	) u_core (
		.cur      (state_q),
		.run_error(err_s1),
		.nxt      (state_nxt)
	);

	// Configuration registers and tuner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q         <= 1'b0;
			run_len_q        <= twgt_pkg::RUN_LENGTH_RST;
			init_gain_p_q    <= twgt_pkg::INIT_GAIN_P_RST;
			init_gain_i_q    <= twgt_pkg::INIT_GAIN_I_RST;
			init_gain_d_q    <= twgt_pkg::INIT_GAIN_D_RST;
			init_step_p_q    <= twgt_pkg::INIT_STEP_P_RST;
			init_step_i_q    <= twgt_pkg::INIT_STEP_I_RST;
			init_step_d_q    <= twgt_pkg::INIT_STEP_D_RST;
			count_q          <= '0;
			state_q.gain[0]  <= twgt_pkg::INIT_GAIN_P_RST;
			state_q.gain[1]  <= twgt_pkg::INIT_GAIN_I_RST;
			state_q.gain[2]  <= twgt_pkg::INIT_GAIN_D_RST;
			state_q.step[0]  <= twgt_pkg::INIT_STEP_P_RST;
			state_q.step[1]  <= twgt_pkg::INIT_STEP_I_RST;
			state_q.step[2]  <= twgt_pkg::INIT_STEP_D_RST;
			state_q.sel      <= twgt_pkg::GAIN_P;
			state_q.phase    <= twgt_pkg::PH_ADD;
			state_q.best     <= '0;
			state_q.baseline <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				twgt_pkg::REG_TUNE_ENABLE: begin
					if (cfg_data[0] && !enable_q) begin
						state_q <= session_start;
						count_q <= '0;
					end
					enable_q <= cfg_data[0];
				end
				twgt_pkg::REG_RUN_LENGTH:  run_len_q     <= cfg_data[twgt_pkg::RUNLEN_W-1:0];
				twgt_pkg::REG_INIT_GAIN_P: init_gain_p_q <= cfg_data;
				twgt_pkg::REG_INIT_GAIN_I: init_gain_i_q <= cfg_data;
				twgt_pkg::REG_INIT_GAIN_D: init_gain_d_q <= cfg_data;
				twgt_pkg::REG_INIT_STEP_P: init_step_p_q <= cfg_data[twgt_pkg::STEP_W-1:0];
				twgt_pkg::REG_INIT_STEP_I: init_step_i_q <= cfg_data[twgt_pkg::STEP_W-1:0];
				twgt_pkg::REG_INIT_STEP_D: init_step_d_q <= cfg_data[twgt_pkg::STEP_W-1:0];
				default: ;
			endcase
		end else if (proceed && enable_q) begin
			if (run_end) begin
				state_q <= state_nxt;
				count_q <= '0;
			end else if (!(&count_q)) begin
				count_q <= count_q + COUNT_WIDTH'(1);
			end
		end
	end

	// Input register: takes a beat whenever it is empty or the held one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			err_s1 <= run_error;
		end
	end

	// Output register: filled at a run end, emptied when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			gain_p_q <= state_nxt.gain[0];
			gain_i_q <= state_nxt.gain[1];
			gain_d_q <= state_nxt.gain[2];
			tuned_q  <= state_nxt.sel;
		end
	end

	assign out_valid  = out_valid_q;
	assign gain_p_out = gain_p_q;
	assign gain_i_out = gain_i_q;
	assign gain_d_out = gain_d_q;
	assign restart    = 1'b1;
	assign tuned_gain = tuned_q;

endmodule
